// ===== hdl/kct_pkg.sv =====
// Shared types and codes for the key/count table.
// Holds the entry record, field widths, opcodes and status codes.
// No dependencies.
package kct_pkg;

  localparam int KEY_W = 31;
  localparam int CNT_W = 31;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_GET   = 3'd1;
  localparam logic [OP_W-1:0] OP_SET   = 3'd2;
  localparam logic [OP_W-1:0] OP_DUMP  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } kct_entry_t;

endpackage

// ===== hdl/key_count_table_core.sv =====
// Top level of the key/count table: a ring of CAPACITY cells and its sequencer.
// Depends on kct_pkg and kct_cell.
//
// Get scans the whole ring once, then delivers the item. Add and set take the same
// scan, deliver the item, then rotate the ring once more to write the entry back.
// Dump scans once, then emits one item per valid slot over a second rotation,
// pausing while the output register is held. A dump of an empty table gives its
// single item straight after the scan, as a get does. Clear goes straight to its
// acknowledgement. The ring moves one slot per cycle, except while a dump holds
// it, and sets all rates. Synchronous reset empties every cell; no clearing pass
// is needed.
module key_count_table_core
  import kct_pkg::*;
#(
  parameter int CAPACITY = 16
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  opcode,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] new_count,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_key,
  output logic [CNT_W-1:0] out_count,
  output logic [ST_W-1:0]  status,
  output logic             last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_REPLY = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DUMP  = 3'd4;

  logic [2:0]       state;
  logic [IW-1:0]    step;
  logic [OP_W-1:0]  op_code;
  logic [KEY_W-1:0] op_key;
  logic [CNT_W-1:0] op_count;

  // What the scan pass learnt about the table.
  logic             match_hit;
  logic [IW-1:0]    match_idx;
  logic [CNT_W-1:0] match_count;
  logic             free_hit;
  logic [IW-1:0]    free_idx;
  logic             any_valid;
  logic [IW-1:0]    last_idx;

  // Pending write-back for the second rotation.
  logic [IW-1:0]    wr_idx;
  kct_entry_t       wr_entry;

  // The ring. Slot s sits in the last cell after s shifts, so the head of the
  // ring shows the slots in ascending order as the step counter advances.
  kct_entry_t chain [CAPACITY];
  kct_entry_t head;
  kct_entry_t feed;
  logic       shift;
  logic       clear_all;

  logic in_accept;
  logic out_free;
  logic out_load;
  logic [KEY_W-1:0] load_key;
  logic [CNT_W-1:0] load_count;
  logic [ST_W-1:0]  load_status;
  logic             load_last;

  // Decision made once the scan is over.
  logic [KEY_W-1:0] r_key;
  logic [CNT_W-1:0] r_count;
  logic [ST_W-1:0]  r_status;
  logic             r_reply;
  logic             r_write;
  logic [IW-1:0]    r_widx;
  logic [CNT_W-1:0] r_wcount;
  logic [CNT_W-1:0] inc_count;

  assign head      = chain[CAPACITY-1];
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign clear_all = in_accept && (opcode == OP_CLEAR);
  assign out_free  = !out_valid || !out_stall;

  // The ring turns continuously during scan and write-back; during a dump it
  // holds whenever a valid entry is at the head and the output cannot take it.
  assign shift = (state == S_SCAN) || (state == S_WRITE) ||
                 ((state == S_DUMP) && (!head.valid || out_free));

  // The write-back replaces the head entry as it wraps round to the first cell.
  assign feed = ((state == S_WRITE) && (step == wr_idx)) ? wr_entry : head;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_ring
    if (g == 0) begin : g_first
      kct_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .clear (clear_all),
        .din   (feed),
        .dout  (chain[g])
      );
    end else begin : g_rest
      kct_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .clear (clear_all),
        .din   (chain[g-1]),
        .dout  (chain[g])
      );
    end
  end

  // Saturating increment of the matched count.
  assign inc_count = (match_count == CNT_MAX) ? match_count : match_count + CNT_W'(1);

  always_comb begin
    r_key    = op_key;
    r_count  = '0;
    r_status = ST_OK;
    r_reply  = 1'b1;
    r_write  = 1'b0;
    r_widx   = match_hit ? match_idx : free_idx;
    r_wcount = '0;
    unique case (op_code)
      OP_ADD: begin
        if (match_hit) begin
          r_count  = inc_count;
          r_write  = 1'b1;
          r_wcount = inc_count;
        end else if (free_hit) begin
          r_count  = CNT_W'(1);
          r_write  = 1'b1;
          r_wcount = CNT_W'(1);
        end else begin
          r_status = ST_FULL;
        end
      end
      OP_GET: begin
        if (match_hit) begin
          r_count = match_count;
        end else begin
          r_status = ST_NOT_FOUND;
        end
      end
      OP_SET: begin
        if (match_hit || free_hit) begin
          r_count  = op_count;
          r_write  = 1'b1;
          r_wcount = op_count;
        end else begin
          r_status = ST_FULL;
        end
      end
      OP_DUMP: begin
        // A table with entries is reported during the second rotation.
        r_key   = '0;
        r_reply = !any_valid;
        r_status = ST_EMPTY;
      end
      default: begin
        // Only clear reaches here: a single acknowledgement.
        r_key = '0;
      end
    endcase
  end

  // Output register loading.
  always_comb begin
    out_load    = 1'b0;
    load_key    = r_key;
    load_count  = r_count;
    load_status = r_status;
    load_last   = 1'b1;
    if ((state == S_REPLY) && r_reply && out_free) begin
      out_load = 1'b1;
    end else if ((state == S_DUMP) && head.valid && out_free) begin
      out_load    = 1'b1;
      load_key    = head.key;
      load_count  = head.count;
      load_status = ST_OK;
      load_last   = (step == last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key   <= load_key;
      out_count <= load_count;
      status    <= load_status;
      last      <= load_last;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      if (shift) begin
        step <= (step == LAST_STEP) ? '0 : step + IW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if ((opcode == OP_ADD) || (opcode == OP_GET) ||
                (opcode == OP_SET) || (opcode == OP_DUMP)) begin
              state <= S_SCAN;
            end else if (opcode == OP_CLEAR) begin
              state <= S_REPLY;
            end
          end
        end
        S_SCAN: begin
          if (step == LAST_STEP) begin
            state <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (!r_reply) begin
            state <= S_DUMP;
          end else if (out_free) begin
            state <= r_write ? S_WRITE : S_IDLE;
          end
        end
        S_WRITE, S_DUMP: begin
          if (shift && (step == LAST_STEP)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item capture, scan bookkeeping and write-back set-up.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_code   <= opcode;
      op_key    <= key;
      op_count  <= new_count;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
      any_valid <= 1'b0;
    end else if (state == S_SCAN) begin
      if (head.valid && (head.key == op_key) && !match_hit) begin
        match_hit   <= 1'b1;
        match_idx   <= step;
        match_count <= head.count;
      end
      if (!head.valid && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= step;
      end
      if (head.valid) begin
        any_valid <= 1'b1;
        last_idx  <= step;
      end
    end
    if ((state == S_REPLY) && r_write && out_free) begin
      wr_idx   <= r_widx;
      wr_entry <= '{valid: 1'b1, key: op_key, count: r_wcount};
    end
  end

  // The step counter sits at zero whenever the ring is at rest.
  a_step_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (step == '0))
    else $error("ring not aligned while idle");

  // A dump must not rotate past a valid entry that could not be delivered.
  a_dump_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DUMP) && head.valid && out_valid && out_stall) |=> $stable(step))
    else $error("dump rotated past an undelivered entry");

  // A write-back rotation ends after exactly one turn of the ring.
  a_write_end: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WRITE) && (step == LAST_STEP)) |=> (state == S_IDLE))
    else $error("write-back did not finish on the last step");

  // Lookup operations always start with a scan.
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (in_accept && ((opcode == OP_ADD) || (opcode == OP_GET) ||
                   (opcode == OP_SET) || (opcode == OP_DUMP)))
      |=> (state == S_SCAN))
    else $error("accepted item did not enter scan");

endmodule

// ===== hdl/kct_cell.sv =====
// One storage cell of the rotating table ring.
// Depends on kct_pkg for the entry record.
module kct_cell
  import kct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  kct_entry_t din,
  output kct_entry_t dout
);

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] count;

  // The valid flag is control state; a clear empties the cell at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key   <= din.key;
      count <= din.count;
    end
  end

  assign dout = '{valid: valid, key: key, count: count};

endmodule

// ===== tb/sv/key_count_table_core_tb.sv =====
// Self-checking testbench for key_count_table_core, the fixed-capacity key/count table.
// It predicts every result from its own copy of the table and checks each one.
// Depends on kct_pkg and the key_count_table_core RTL.
module key_count_table_core_tb;
  import kct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 16;

  // Opcodes 5 to 7 are not defined. The block must drop them without a result.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // One result item as the block should present it.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [ST_W-1:0]  status;
    logic             last;
  } count_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  opcode = OP_ADD;
  logic [KEY_W-1:0] key = '0;
  logic [CNT_W-1:0] new_count = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KEY_W-1:0] out_key;
  logic [CNT_W-1:0] out_count;
  logic [ST_W-1:0]  status;
  logic             last;

  // The testbench's own copy of the table. Keys and counts are only read
  // while the slot is marked as occupied, so they need no reset value.
  logic             slot_used  [TABLE_SLOTS];
  logic [KEY_W-1:0] slot_key   [TABLE_SLOTS];
  logic [CNT_W-1:0] slot_count [TABLE_SLOTS];

  // Results predicted but not yet seen, oldest first.
  count_result_t pending_results[$];

  int mismatch_count = 0;
  // While non-zero, the sender runs back to back with no gaps.
  int sender_burst = 0;

  key_count_table_core #(
    .CAPACITY(TABLE_SLOTS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .key      (key),
    .new_count(new_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_key  (out_key),
    .out_count(out_count),
    .status   (status),
    .last     (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void expect_result(input logic [KEY_W-1:0] k,
                                        input logic [CNT_W-1:0] c,
                                        input logic [ST_W-1:0] st,
                                        input logic lst);
    count_result_t r;
    r.key    = k;
    r.count  = c;
    r.status = st;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  // Slot that holds the key, or -1 when the key is absent.
  function automatic int slot_of_key(input logic [KEY_W-1:0] k);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // New keys always go into the lowest free slot; -1 means the table is full.
  function automatic int lowest_free_slot();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!slot_used[i]) return i;
    end
    return -1;
  endfunction

  // Applies one accepted item to the copy of the table and queues the results
  // that it should cause.
  function automatic void apply_table_op(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] k,
                                         input logic [CNT_W-1:0] nc);
    int s;
    int final_slot;
    s = -1;
    final_slot = -1;
    case (op)
      OP_ADD: begin
        s = slot_of_key(k);
        if (s >= 0) begin
          // The count saturates rather than wrapping.
          if (slot_count[s] != CNT_MAX) slot_count[s] = slot_count[s] + CNT_W'(1);
          expect_result(k, slot_count[s], ST_OK, 1'b1);
        end else begin
          s = lowest_free_slot();
          if (s < 0) begin
            expect_result(k, '0, ST_FULL, 1'b1);
          end else begin
            slot_used[s]  = 1'b1;
            slot_key[s]   = k;
            slot_count[s] = CNT_W'(1);
            expect_result(k, CNT_W'(1), ST_OK, 1'b1);
          end
        end
      end
      OP_GET: begin
        s = slot_of_key(k);
        if (s >= 0) expect_result(k, slot_count[s], ST_OK, 1'b1);
        else expect_result(k, '0, ST_NOT_FOUND, 1'b1);
      end
      OP_SET: begin
        s = slot_of_key(k);
        if (s < 0) begin
          s = lowest_free_slot();
          if (s >= 0) begin
            slot_used[s] = 1'b1;
            slot_key[s]  = k;
          end
        end
        if (s < 0) begin
          expect_result(k, '0, ST_FULL, 1'b1);
        end else begin
          slot_count[s] = nc;
          expect_result(k, nc, ST_OK, 1'b1);
        end
      end
      OP_DUMP: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (slot_used[i]) final_slot = i;
        end
        if (final_slot < 0) begin
          expect_result('0, '0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i]) begin
              expect_result(slot_key[i], slot_count[i], ST_OK, i == final_slot);
            end
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < TABLE_SLOTS; i++) slot_used[i] = 1'b0;
        expect_result('0, '0, ST_OK, 1'b1);
      end
      default: begin
        // Undefined opcodes leave the table alone and produce nothing.
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sender gap in cycles: mostly none or short, now and then long, and from
  // time to time a burst of back-to-back items.
  function automatic int sender_gap();
    int r;
    if (sender_burst > 0) begin
      sender_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      sender_burst = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values for keys and counts: small numbers, values near the top of the
  // range (so that adds reach saturation), and anything at all.
  function automatic logic [KEY_W-1:0] random_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return KEY_W'($urandom_range(0, 15));
    if (r < 40) return KEY_MAX - KEY_W'($urandom_range(0, 3));
    return KEY_W'($urandom());
  endfunction

  // Presents one item, holds it steady until it is taken, then updates the
  // prediction. Must be called just after a rising edge. in_valid is left high
  // so that a following item can go straight out; the next call lowers it only
  // if it wants a gap, which keeps to one assignment per time step.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic [KEY_W-1:0] k,
                           input logic [CNT_W-1:0] nc);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    key       <= k;
    new_count <= nc;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_table_op(op, k, nc);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty dump, miss on key 0, creation and increment of key 0, saturation of
  // the largest count on the largest key, overwrite by set, and the undefined
  // opcodes.
  task automatic test_basic_ops();
    send_item(OP_DUMP, '0, '0);
    send_item(OP_GET, '0, '0);
    send_item(OP_ADD, '0, '0);
    send_item(OP_ADD, '0, '0);
    send_item(OP_SET, KEY_MAX, CNT_MAX - CNT_W'(1));
    send_item(OP_ADD, KEY_MAX, '0);
    send_item(OP_ADD, KEY_MAX, '0);
    send_item(OP_SET, '0, '0);
    for (logic [OP_W-1:0] op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) begin
      send_item(op, KEY_W'($urandom()), CNT_W'($urandom()));
      if (op == OP_UNUSED_HI) break;
    end
  endtask

  // Fills every slot, then checks that a new key is refused by both add and
  // set, dumps the full table and empties it.
  task automatic test_full_table();
    logic [KEY_W-1:0] k;
    for (int i = 1; i < TABLE_SLOTS - 1; i++) begin
      k = {4'(i), 27'h0} | KEY_W'(i * 3);
      if (i % 2 == 1) send_item(OP_ADD, k, '0);
      else send_item(OP_SET, k, CNT_W'($urandom()));
    end
    send_item(OP_ADD, 31'h2AAA_AAAA, '0);
    send_item(OP_SET, 31'h5555_5555, CNT_MAX);
    send_item(OP_DUMP, '0, '0);
    send_item(OP_CLEAR, KEY_W'($urandom()), CNT_W'($urandom()));
  endtask

  // Random traffic over a pool of keys. A pool smaller than the table gives
  // many hits and no overflow; a larger one keeps the table full most of the
  // time. A few fresh keys mix in misses, and clears reset the fill level.
  task automatic test_random_traffic(input int item_total, input int pool_size);
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] k;
    logic [OP_W-1:0]  op;
    int sel;
    int sent;
    sent = 0;
    repeat (pool_size) key_pool.push_back(random_value());
    while (sent < item_total) begin
      sel = $urandom_range(0, 99);
      if (sel < 36) op = OP_ADD;
      else if (sel < 56) op = OP_GET;
      else if (sel < 76) op = OP_SET;
      else if (sel < 88) op = OP_DUMP;
      else if (sel < 92) op = OP_CLEAR;
      else op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_size - 1)];
      else k = KEY_W'($urandom());
      send_item(op, k, random_value());
      // Ignored items do not count towards the total.
      if (op < OP_UNUSED_LO) sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver stalls at random: mostly short stalls, a few long ones, and
  // every so often a long stretch with no stall at all. out_stall gets only
  // one assignment in any time step.
  initial begin : stall_pattern
    int hold;
    int run;
    forever begin
      hold = $urandom_range(0, 99);
      if (hold < 40) hold = 0;
      else if (hold < 92) hold = $urandom_range(1, 3);
      else hold = $urandom_range(10, 40);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      run = ($urandom_range(0, 99) < 5) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
    end
  end

  // Every result taken at a rising edge is compared with the oldest prediction.
  // Signals are read just after the edge, before any assignment of that edge
  // has landed, so they hold the values the block saw at the edge.
  always @(posedge clk) begin : result_check
    count_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item key=%h count=%h status=%0d last=%b",
                                  out_key, out_count, status, last));
      end else begin
        want = pending_results.pop_front();
        if (out_key !== want.key)
          report_mismatch($sformatf("out_key %h, expected %h", out_key, want.key));
        if (out_count !== want.count)
          report_mismatch($sformatf("out_count %h, expected %h (key %h)",
                                    out_count, want.count, want.key));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d (key %h)",
                                    status, want.status, want.key));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, expected %b (key %h)",
                                    last, want.last, want.key));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    for (int i = 0; i < TABLE_SLOTS; i++) slot_used[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_full_table();
    test_random_traffic(180, 10);
    test_random_traffic(180, 40);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // An add or set goes on rotating the ring after its result; give any
    // stray result time to show.
    repeat (3 * TABLE_SLOTS + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Generous limit: every item a full dump with every result stalled at the
  // longest, plus the longest sender gap, several times over.
  initial begin : watchdog
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
